FILE: rtl/core/ds_twr_distance_defines.svh
// assertion macros for the ds-twr distance core
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef DS_TWR_DISTANCE_DEFINES_SVH
`define DS_TWR_DISTANCE_DEFINES_SVH

// same-cycle implication, held off during reset
`define DTD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ds_twr_distance: same-cycle check failed");

// next-cycle implication, held off during reset
`define DTD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ds_twr_distance: next-cycle check failed");

`endif

FILE: rtl/core/dtd_pkg.sv
// shared types and constants of the ds-twr distance core
// no dependencies
package dtd_pkg;

    typedef struct packed {
        logic [39:0] poll_tx_time;
        logic [39:0] resp_rx_time;
        logic [39:0] final_tx_time;
        logic [39:0] poll_rx_time;
        logic [39:0] resp_tx_time;
        logic [39:0] final_rx_time;
        logic [15:0] poll_first_path;
        logic [15:0] resp_first_path;
        logic [15:0] final_first_path;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] distance_cm;
        logic [1:0]         range_status;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_FIRST_PATH = 2'd2
    } t_status;

    // flags that travel beside the arithmetic
    typedef struct packed {
        logic neg;
        logic zero;
        logic bad;
    } t_side;

    localparam logic [7:0] CFG_ANT_DELAY   = 8'd0;
    localparam logic [7:0] CFG_DIST_OFFSET = 8'd1;
    localparam logic [7:0] CFG_MAX_DIST    = 8'd2;
    localparam logic [7:0] CFG_FP_MIN      = 8'd3;

    localparam logic [15:0] RST_ANT_DELAY   = 16'd13914;
    localparam logic [9:0]  RST_DIST_OFFSET = 10'd30;
    localparam logic [15:0] RST_MAX_DIST    = 16'd3000;
    localparam logic [15:0] RST_FP_MIN      = 16'd530;

    // quotient bits kept by the divider, time of flight capped at 2^33
    localparam int          QUOT_BITS  = 34;
    localparam logic [33:0] TOF_CAP    = 34'h2_0000_0000;
    // 307389 / 655360 = 307389 / 2^16 / 10
    localparam logic [18:0] SCALE_NUM  = 19'd307389;
    localparam int          PROD_BITS  = 53;
    localparam int          SCALE_SHR  = 16;
    localparam logic [13:0] RECIP_TEN  = 14'd6554;
    localparam logic [3:0]  TEN        = 4'd10;

endpackage

FILE: rtl/core/dtd_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on dtd_pkg
module dtd_div #(
    parameter int IB = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [2*IB-1:0]                i_num,
    input  logic [IB+1:0]                  i_den,
    input  dtd_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [dtd_pkg::QUOT_BITS-1:0]  o_quot,
    output logic                           o_ovf,
    output dtd_pkg::t_side                 o_side
);
    import dtd_pkg::*;

    localparam int QB = QUOT_BITS;
    localparam int DW = 2*IB + QB + 2;

    logic [DW-1:0]  r_rem  [0:QB];
    logic [IB+1:0]  r_den  [0:QB];
    logic [QB-1:0]  r_q    [0:QB];
    logic           r_v    [0:QB];
    logic           r_ovf  [0:QB];
    t_side          r_side [0:QB];

    // entry stage, quotient too large for QB bits flags overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DW'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= DW'(i_num) >= (DW'(i_den) << QB);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int SH = QB - 1 - k;
        logic [DW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = DW'(r_den[k]) << SH;
        assign w_ge = r_rem[k] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? r_rem[k] - w_sh : r_rem[k];
                r_den[k+1]  <= r_den[k];
                r_q[k+1]    <= r_q[k] | (w_ge ? (QB'(1) << SH) : '0);
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quot  = r_q[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_side  = r_side[QB];

endmodule

FILE: rtl/core/ds_twr_distance.sv
// top level of the double-sided two-way ranging distance core
// depends on dtd_pkg, dtd_div and ds_twr_distance_defines.svh
//
// channel   direction  handshake                 word
// input     in         i_in_valid / o_in_ready   t_in_word i_in
// result    out        o_out_valid / i_out_ready t_out_word o_out
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word enters per cycle unless a waiting result freezes the pipeline
// the divider resolves one quotient bit per stage over 34 stages
// synchronous active-low reset clears valid bits and loads register defaults
// the whole pipeline advances together; it freezes while a result waits
// config writes are always taken and must only land while the core is idle
module ds_twr_distance #(
    parameter int TS_BITS       = 40,
    parameter int INTERVAL_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dtd_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dtd_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import dtd_pkg::*;

    `include "ds_twr_distance_defines.svh"

    localparam int TS = TS_BITS;
    localparam int IB = INTERVAL_BITS;
    localparam int NW = 2*IB;
    // wide enough for an interval and for a clamp bound beside it
    localparam int XW = ((TS > IB) ? TS : IB) + 1;
    localparam logic [IB-1:0] IMAX = '1;
    localparam int NCHUNK = 5;

    // ---------------- configuration registers ----------------
    logic [15:0] r_ant_delay;
    logic [9:0]  r_dist_offset;
    logic [15:0] r_max_dist;
    logic [15:0] r_fp_min;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant_delay   <= RST_ANT_DELAY;
            r_dist_offset <= RST_DIST_OFFSET;
            r_max_dist    <= RST_MAX_DIST;
            r_fp_min      <= RST_FP_MIN;
        end else if (i_cfg_valid) begin
            // unknown indices fall through and are ignored
            unique case (i_cfg_index)
                CFG_ANT_DELAY:   r_ant_delay   <= i_cfg_data;
                CFG_DIST_OFFSET: r_dist_offset <= i_cfg_data[9:0];
                CFG_MAX_DIST:    r_max_dist    <= i_cfg_data;
                CFG_FP_MIN:      r_fp_min      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    // a single enable: everything moves unless the result register is held
    logic r_out_v;
    logic w_en;

    assign w_en       = !r_out_v || i_out_ready;
    assign o_in_ready = w_en;

    // round interval: minus antenna delay, clamped at zero and at IMAX
    function automatic logic [IB-1:0] f_round(logic [39:0] later, logic [39:0] earlier,
                                              logic [15:0] ad);
        logic [TS-1:0] t;
        logic [XW-1:0] d;
        t = TS'(later) - TS'(earlier);
        d = XW'(t);
        if (d <= XW'(ad)) return '0;
        d = d - XW'(ad);
        if (d > XW'(IMAX)) return IMAX;
        return d[IB-1:0];
    endfunction

    // reply interval: plus antenna delay, clamped at IMAX
    function automatic logic [IB-1:0] f_reply(logic [39:0] later, logic [39:0] earlier,
                                              logic [15:0] ad);
        logic [TS-1:0] t;
        logic [XW-1:0] d;
        t = TS'(later) - TS'(earlier);
        d = XW'(t);
        if (d >= XW'(IMAX)) return IMAX;
        d = d + XW'(ad);
        if (d > XW'(IMAX)) return IMAX;
        return d[IB-1:0];
    endfunction

    // ---------------- stage 1: intervals and first-path check ----------------
    logic          r_v1;
    logic [IB-1:0] r_round1, r_round2, r_reply1, r_reply2;
    logic          r_bad1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_round1 <= f_round(i_in.resp_rx_time, i_in.poll_tx_time, r_ant_delay);
            r_round2 <= f_round(i_in.final_rx_time, i_in.resp_tx_time, r_ant_delay);
            r_reply1 <= f_reply(i_in.resp_tx_time, i_in.poll_rx_time, r_ant_delay);
            r_reply2 <= f_reply(i_in.final_tx_time, i_in.resp_rx_time, r_ant_delay);
            r_bad1   <= (i_in.poll_first_path < r_fp_min)
                     || (i_in.resp_first_path < r_fp_min)
                     || (i_in.final_first_path < r_fp_min);
        end
    end

    // ---------------- stage 2: partial products and divisor ----------------
    // second operand split at bit 16 so no multiplier exceeds 32 x 16
    logic             r_v2;
    logic [IB+15:0]   r_pa_lo, r_pb_lo;
    logic [NW-17:0]   r_pa_hi, r_pb_hi;
    logic [IB+1:0]    r_sum2;
    logic             r_bad2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa_lo <= (IB+16)'(r_round1) * (IB+16)'(r_round2[15:0]);
            r_pa_hi <= (NW-16)'(r_round1) * (NW-16)'(r_round2[IB-1:16]);
            r_pb_lo <= (IB+16)'(r_reply1) * (IB+16)'(r_reply2[15:0]);
            r_pb_hi <= (NW-16)'(r_reply1) * (NW-16)'(r_reply2[IB-1:16]);
            r_sum2  <= (IB+2)'(r_round1) + (IB+2)'(r_round2)
                     + (IB+2)'(r_reply1) + (IB+2)'(r_reply2);
            r_bad2  <= r_bad1;
        end
    end

    // ---------------- stage 3: full products ----------------
    logic          r_v3;
    logic [NW-1:0] r_prod_a, r_prod_b;
    logic [IB+1:0] r_sum3;
    logic          r_bad3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod_a <= NW'(r_pa_lo) + (NW'(r_pa_hi) << 16);
            r_prod_b <= NW'(r_pb_lo) + (NW'(r_pb_hi) << 16);
            r_sum3   <= r_sum2;
            r_bad3   <= r_bad2;
        end
    end

    // ---------------- stage 4: magnitude of the numerator ----------------
    logic          r_v4;
    logic [NW-1:0] r_num4;
    logic [IB+1:0] r_sum4;
    t_side         r_side4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num4       <= (r_prod_a < r_prod_b) ? r_prod_b - r_prod_a
                                                  : r_prod_a - r_prod_b;
            r_sum4       <= r_sum3;
            r_side4.neg  <= r_prod_a < r_prod_b;
            r_side4.zero <= r_sum3 == '0;
            r_side4.bad  <= r_bad3;
        end
    end

    // ---------------- divider ----------------
    logic                 w_dv;
    logic [QUOT_BITS-1:0] w_quot;
    logic                 w_ovf;
    t_side                w_dside;

    dtd_div #(
        .IB (IB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r_num4),
        .i_den   (r_sum4),
        .i_side  (r_side4),
        .o_valid (w_dv),
        .o_quot  (w_quot),
        .o_ovf   (w_ovf),
        .o_side  (w_dside)
    );

    // ---------------- stage 5: cap and scale ----------------
    logic                 r_v5;
    logic [PROD_BITS-1:0] r_scaled;
    t_side                r_side5;
    logic [33:0]          w_tof;

    // cap at 2^33: the saturated distance is the same either way
    assign w_tof = (w_ovf || (w_quot[33] && (w_quot[32:0] != '0))) ? TOF_CAP : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scaled <= PROD_BITS'(w_tof) * PROD_BITS'(SCALE_NUM);
            r_side5  <= w_dside;
        end
    end

    // ---------------- stages 6 to 10: divide by ten, a byte per stage ----------------
    logic [39:0] r_dx   [0:NCHUNK-1];
    logic [39:0] r_dq   [0:NCHUNK-1];
    logic [3:0]  r_dr   [0:NCHUNK-1];
    logic        r_dv   [0:NCHUNK-1];
    t_side       r_dside[0:NCHUNK-1];

    logic [39:0] w_cx   [0:NCHUNK];
    logic [39:0] w_cq   [0:NCHUNK];
    logic [3:0]  w_cr   [0:NCHUNK];
    logic        w_cv   [0:NCHUNK];
    t_side       w_cside[0:NCHUNK];

    assign w_cx[0]    = 40'(r_scaled[PROD_BITS-1:SCALE_SHR]);
    assign w_cq[0]    = '0;
    assign w_cr[0]    = '0;
    assign w_cv[0]    = r_v5;
    assign w_cside[0] = r_side5;

    for (genvar c = 0; c < NCHUNK; c++) begin : g_ten
        logic [11:0] w_part;
        logic [25:0] w_mul;
        logic [7:0]  w_qd;
        logic [11:0] w_rem;

        // remainder below ten, so the partial dividend stays under 2560
        assign w_part = {w_cr[c], w_cx[c][39-8*c -: 8]};
        assign w_mul  = 26'(w_part) * 26'(RECIP_TEN);
        assign w_qd   = w_mul[23:16];
        assign w_rem  = w_part - 12'(w_qd) * 12'(TEN);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[c] <= 1'b0;
            end else if (w_en) begin
                r_dv[c] <= w_cv[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dx[c]    <= w_cx[c];
                r_dq[c]    <= w_cq[c] | (40'(w_qd) << (32 - 8*c));
                r_dr[c]    <= w_rem[3:0];
                r_dside[c] <= w_cside[c];
            end
        end

        assign w_cx[c+1]    = r_dx[c];
        assign w_cq[c+1]    = r_dq[c];
        assign w_cr[c+1]    = r_dr[c];
        assign w_cv[c+1]    = r_dv[c];
        assign w_cside[c+1] = r_dside[c];
    end

    // ---------------- stage 11: sign, offset, saturate, status ----------------
    t_out_word          r_out;
    logic signed [41:0] w_mag;
    logic signed [41:0] w_dist;
    logic signed [31:0] w_sat;
    t_status            w_status;

    always_comb begin
        w_mag  = $signed({2'b00, w_cq[NCHUNK]});
        w_dist = (w_cside[NCHUNK].neg ? -w_mag : w_mag) - $signed(42'(r_dist_offset));
        priority if (w_dist > 42'sd2147483647) begin
            w_sat = 32'sh7fff_ffff;
        end else if (w_dist < -42'sd2147483648) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_dist[31:0];
        end
        if (w_cside[NCHUNK].zero) begin
            // zero divisor reports distance zero, out of range unless the first path is bad
            w_sat = '0;
        end
        priority if (w_cside[NCHUNK].bad) begin
            w_status = ST_FIRST_PATH;
        end else if (w_cside[NCHUNK].zero || w_sat < 0
                     || w_sat > $signed({16'd0, r_max_dist})) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_cv[NCHUNK];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.distance_cm  <= w_sat;
            r_out.range_status <= w_status;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // ---------------- checks ----------------
    `DTD_ASSERT_IMP(a_ok_in_range, o_out_valid && (o_out.range_status == ST_OK), !o_out.distance_cm[31] && (o_out.distance_cm <= $signed({16'd0, r_max_dist})))
    `DTD_ASSERT_NXT(a_zero_div, w_en && w_cv[NCHUNK] && w_cside[NCHUNK].zero && !w_cside[NCHUNK].bad, (o_out.distance_cm == 32'sd0) && (o_out.range_status == ST_RANGE))
    `DTD_ASSERT_NXT(a_stall_holds, !w_en && r_dv[NCHUNK-1], r_dv[NCHUNK-1] && $stable(r_dq[NCHUNK-1]))

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the ds-twr distance core
// depends on dtd_pkg and ds_twr_distance; drives timestamp words, checks results
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dtd_pkg::*;

    localparam int LATENCY = 46;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    ds_twr_distance dut (.*);

    // model copy of the registers
    logic [15:0] model_delay;
    logic [9:0]  dist_offset;
    logic [15:0] max_dist;
    logic [15:0] fp_min;

    t_out_word   pending_ranges[$];
    int          fail_count;
    int          words_sent;
    int          results_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    // directed rows: word, expected result, whether the expected result is typed in
    typedef struct {
        t_in_word  w;
        t_out_word r;
        bit        fixed;
    } t_row;

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // interval modulo 2^40, rounds lose the antenna delay
    function automatic logic [31:0] round_ticks(logic [39:0] later, logic [39:0] earlier);
        logic [39:0] d;
        d = later - earlier;
        if (d <= model_delay) return 32'd0;
        d = d - model_delay;
        return (d > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    endfunction

    // replies gain the antenna delay
    function automatic logic [31:0] reply_ticks(logic [39:0] later, logic [39:0] earlier);
        logic [40:0] d;
        d = {1'b0, later - earlier};
        if (d >= 41'hFFFF_FFFF) return 32'hFFFF_FFFF;
        d = d + model_delay;
        return (d > 41'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    endfunction

    function automatic t_out_word range_of(t_in_word w);
        logic [31:0]        rd1, rd2, rp1, rp2;
        logic [33:0]        total;
        logic [63:0]        pa, pb, num;
        logic [63:0]        tof;
        logic [63:0]        q;
        logic signed [65:0] dist_val;
        bit                 neg;
        t_out_word          r;
        rd1 = round_ticks(w.resp_rx_time, w.poll_tx_time);
        rd2 = round_ticks(w.final_rx_time, w.resp_tx_time);
        rp1 = reply_ticks(w.resp_tx_time, w.poll_rx_time);
        rp2 = reply_ticks(w.final_tx_time, w.resp_rx_time);
        total = 34'(rd1) + rd2 + rp1 + rp2;
        dist_val = 0;
        if (total == 0) begin
            r.range_status = ST_RANGE;
        end else begin
            pa = 64'(rd1) * rd2;
            pb = 64'(rp1) * rp2;
            neg = pa < pb;
            num = neg ? pb - pa : pa - pb;
            tof = num / total;
            if (tof > 64'(TOF_CAP)) tof = 64'(TOF_CAP);
            q = (tof * 64'd307389) / 64'd655360;
            dist_val = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
            dist_val = dist_val - $signed({56'd0, dist_offset});
            if (dist_val > 66'sd2147483647) dist_val = 66'sd2147483647;
            if (dist_val < -66'sd2147483648) dist_val = -66'sd2147483648;
            r.range_status = (dist_val < 0 || dist_val > $signed({50'd0, max_dist}))
                           ? ST_RANGE : ST_OK;
        end
        if (w.poll_first_path < fp_min || w.resp_first_path < fp_min
                || w.final_first_path < fp_min)
            r.range_status = ST_FIRST_PATH;
        r.distance_cm = dist_val[31:0];
        return r;
    endfunction

    // plausible exchange: tof, replies and drift chosen, stamps with random bases
    function automatic t_in_word random_exchange();
        t_in_word    w;
        logic [39:0] flight, rep1, rep2;
        flight = 40'($urandom_range(0, 3000));
        rep1 = 40'($urandom_range(0, 1) ? 64'($urandom_range(20000, 2000000))
                                        : {$urandom, $urandom} % 64'h1_0000_0000);
        rep2 = 40'($urandom_range(0, 1) ? 64'($urandom_range(20000, 2000000))
                                        : {$urandom, $urandom} % 64'h1_0000_0000);
        w.poll_tx_time  = 40'({$urandom, $urandom});
        w.poll_rx_time  = 40'({$urandom, $urandom});
        w.resp_tx_time  = w.poll_rx_time + rep1 - model_delay;
        w.resp_rx_time  = w.poll_tx_time + rep1 + 2 * flight + model_delay
                        + 40'($urandom_range(0, 40));
        w.final_tx_time = w.resp_rx_time + rep2 - model_delay;
        w.final_rx_time = w.resp_tx_time + rep2 + 2 * flight + model_delay
                        + 40'($urandom_range(0, 40));
        w.poll_first_path  = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(600, 65535));
        w.resp_first_path  = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(600, 65535));
        w.final_first_path = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(600, 65535));
        // some noise words with every bit random
        if ($urandom_range(0, 9) == 0) w = {$urandom, $urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom, $urandom,
                                            $urandom};
        return w;
    endfunction

    // valid stays up between back-to-back words and drops only while idling
    task automatic send_word(t_in_word w);
        bit idle;
        idle = send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct;
        while (idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            idle = send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct;
        end
        pending_ranges.push_back(range_of(w));
        i_in <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ANT_DELAY:   model_delay = val;
            CFG_DIST_OFFSET: dist_offset = val[9:0];
            CFG_MAX_DIST:    max_dist    = val;
            CFG_FP_MIN:      fp_min      = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait for the pipe to drain, then a little slack
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end

    // result checker against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_ranges.size() == 0) begin
                $error("result word with nothing expected: %h", o_out);
                fail_count++;
            end else begin
                exp_r = pending_ranges.pop_front();
                if (o_out.distance_cm !== exp_r.distance_cm) begin
                    $error("distance_cm expected %0d actual %0d",
                           exp_r.distance_cm, o_out.distance_cm);
                    fail_count++;
                end
                if (o_out.range_status !== exp_r.range_status) begin
                    $error("range_status expected %0d actual %0d",
                           exp_r.range_status, o_out.range_status);
                    fail_count++;
                end
            end
        end
    end

    // overall time limit
    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_row       rows[$];
        t_row       row;
        t_in_word   z;
        t_out_word  r;
        int         ph;
        logic [7:0] ridx;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        words_sent = 0;
        results_seen = 0;
        model_delay = RST_ANT_DELAY;
        dist_offset = RST_DIST_OFFSET;
        max_dist = RST_MAX_DIST;
        fp_min = RST_FP_MIN;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset values
        z = '0;
        z.poll_first_path = 16'hFFFF;
        z.resp_first_path = 16'hFFFF;
        z.final_first_path = 16'hFFFF;
        // all stamps equal: rounds clamp to zero, replies are the antenna delay,
        // so the flight time is minus half the delay, well below zero
        r.distance_cm = -32'sd3293;
        r.range_status = ST_RANGE;
        rows.push_back('{z, r, 1'b1});
        // same with a bad first path: status 2 wins
        row.w = z;
        row.w.resp_first_path = 16'd0;
        r.range_status = ST_FIRST_PATH;
        rows.push_back('{row.w, r, 1'b1});
        // the final first path at the threshold minus one, then every first path at it
        row.w = z;
        row.w.final_first_path = RST_FP_MIN - 1;
        rows.push_back('{row.w, r, 1'b1});
        row.w = z;
        row.w.poll_first_path = RST_FP_MIN;
        row.w.resp_first_path = RST_FP_MIN;
        row.w.final_first_path = RST_FP_MIN;
        r.range_status = ST_RANGE;
        rows.push_back('{row.w, r, 1'b1});
        // all ones on every field
        row.w = '1;
        rows.push_back('{row.w, r, 1'b0});
        // wrapped intervals, huge rounds, huge replies (negative), extremes
        row.w = z;
        row.w.poll_tx_time = 40'hFF_FFFF_FFF0;
        row.w.resp_rx_time = 40'h00_0010_0000;
        row.w.final_rx_time = 40'hFF_FFFF_FFFF;
        rows.push_back('{row.w, r, 1'b0});
        row.w = z;
        row.w.resp_tx_time = 40'hFF_FFFF_FFFF;
        row.w.final_tx_time = 40'h80_0000_0000;
        rows.push_back('{row.w, r, 1'b0});
        row.w = z;
        row.w.resp_rx_time = 40'hFF_FFFF_FFFF;
        row.w.final_rx_time = 40'hFF_FFFF_FFFF;
        rows.push_back('{row.w, r, 1'b0});
        row.w = z;
        row.w.resp_rx_time = 40'h00_FFFF_0000;
        row.w.final_rx_time = 40'h00_0001_0000;
        row.w.final_tx_time = 40'h00_FFFF_0000;
        rows.push_back('{row.w, r, 1'b0});
        for (int k = 0; k < 8; k++) begin
            row.w = random_exchange();
            rows.push_back('{row.w, r, 1'b0});
        end
        foreach (rows[k]) begin
            if (rows[k].fixed && range_of(rows[k].w) !== rows[k].r) begin
                $error("typed-in row %0d disagrees: expected %h", k, rows[k].r);
                fail_count++;
            end
            send_word(rows[k].w);
        end
        drain();

        // zero antenna delay with all stamps equal: zero divisor
        write_reg(CFG_ANT_DELAY, 16'd0);
        rows.delete();
        r.distance_cm = 32'sd0;
        r.range_status = ST_RANGE;
        rows.push_back('{z, r, 1'b1});
        row.w = z;
        row.w.poll_first_path = 16'd0;
        r.range_status = ST_FIRST_PATH;
        rows.push_back('{row.w, r, 1'b1});
        foreach (rows[k]) begin
            if (rows[k].fixed && range_of(rows[k].w) !== rows[k].r) begin
                $error("typed-in zero divisor row %0d disagrees: expected %h", k, rows[k].r);
                fail_count++;
            end
            send_word(rows[k].w);
        end
        drain();
        write_reg(CFG_ANT_DELAY, RST_ANT_DELAY);

        // pressure: receiver held off while the sender keeps offering
        hold_off = 1'b1;
        fork
            repeat (60) send_word(random_exchange());
            repeat (300) @(posedge i_clk);
        join_any
        hold_off = 1'b0;
        wait fork;
        drain();

        // random phases over several register settings, extremes included
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(CFG_ANT_DELAY, 16'd0);     write_reg(CFG_DIST_OFFSET, 16'd0);
                         write_reg(CFG_MAX_DIST, 16'd0);      write_reg(CFG_FP_MIN, 16'd0); end
                1: begin write_reg(CFG_ANT_DELAY, 16'hFFFF);  write_reg(CFG_DIST_OFFSET, 16'h3FF);
                         write_reg(CFG_MAX_DIST, 16'hFFFF);   write_reg(CFG_FP_MIN, 16'hFFFF); end
                2: begin write_reg(CFG_ANT_DELAY, RST_ANT_DELAY); write_reg(CFG_DIST_OFFSET, 16'd30);
                         write_reg(CFG_MAX_DIST, RST_MAX_DIST);   write_reg(CFG_FP_MIN, RST_FP_MIN); end
                default: begin
                    // unknown indexes must be ignored
                    ridx = 8'($urandom_range(4, 255));
                    write_reg(ridx, 16'($urandom));
                    write_reg(CFG_ANT_DELAY, 16'($urandom));
                    write_reg(CFG_DIST_OFFSET, 16'($urandom));
                    write_reg(CFG_MAX_DIST, 16'($urandom));
                    write_reg(CFG_FP_MIN, 16'($urandom_range(0, 1200)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            repeat (120) send_word(random_exchange());
            drain();
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        $display("covered %0d words with %0d results checked over eight register settings,",
                 words_sent, results_seen);
        $display("zero divisor, first-path and range cases, wrapped stamps and a long stall");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
